@@ rtl/insertable_array_store_unit_assert.svh @@
// assertion macros for the insertable array store unit
// used by the rtl modules that carry concurrent checks; needs no other file
`ifndef INSERTABLE_ARRAY_STORE_UNIT_ASSERT_SVH
`define INSERTABLE_ARRAY_STORE_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define IAS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ias same-cycle check failed");

// next-cycle implication, checked out of reset
`define IAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ias next-cycle check failed");

`endif

@@ rtl/ias_pkg.sv @@
// shared types, widths and codes of the insertable array store unit
// no dependencies; used by ias_ctrl, ias_dp and the top level
package ias_pkg;

  // store geometry
  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = 5;
  localparam int WORD_W  = 32;
  localparam int OP_W    = 3;
  localparam int ST_W    = 2;

  // stream payload widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [OP_W-1:0]          op_t;
  typedef logic [ST_W-1:0]          status_t;

  // operation codes
  localparam op_t OP_APPEND   = 3'd0;
  localparam op_t OP_WRITE    = 3'd1;
  localparam op_t OP_READ     = 3'd2;
  localparam op_t OP_INSERT   = 3'd3;
  localparam op_t OP_REMOVE   = 3'd4;
  localparam op_t OP_CLEAR    = 3'd5;
  localparam op_t OP_SETCOUNT = 3'd6;

  // status codes
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_FULL   = 2'd1;
  localparam status_t ST_BADIDX = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;  // capture the incoming item
    logic exec;  // run the captured operation and load the result register
  } cmd_t;

endpackage

@@ rtl/ias_ctrl.sv @@
// controller of the insertable array store unit: item sequencing and result valid
// depends on ias_pkg and insertable_array_store_unit_assert.svh
`include "insertable_array_store_unit_assert.svh"

module ias_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ias_pkg::cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;
  logic out_free;

  // handshake decode
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign cmd_o.load  = accept;
  assign cmd_o.exec  = (state_q == ST_EXEC) & out_free;
  assign out_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_EXEC;
      ST_EXEC: if (cmd_o.exec) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // result valid: set on execute, cleared when the transfer completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `IAS_ASSERT_NEXT(a_accept_to_exec, clk_i, rst_ni, accept, state_q == ST_EXEC)
  `IAS_ASSERT_NEXT(a_exec_gives_result, clk_i, rst_ni, cmd_o.exec,
                   out_valid_q && state_q == ST_IDLE)
  `IAS_ASSERT_NEXT(a_blocked_exec_waits, clk_i, rst_ni,
                   state_q == ST_EXEC && !out_free, state_q == ST_EXEC && !in_ready_o)

endmodule

@@ rtl/ias_dp.sv @@
// datapath of the insertable array store unit: entry registers, count,
// capacity register and result register; depends on ias_pkg
module ias_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ias_pkg::cmd_t          cmd_i,
  input  ias_pkg::op_t           op_i,
  input  logic [ias_pkg::CNT_W-1:0] pos_i,
  input  ias_pkg::word_t         val_i,
  input  logic                   cfg_valid_i,
  input  logic [ias_pkg::CNT_W-1:0] cfg_data_i,
  output ias_pkg::word_t         read_value_o,
  output ias_pkg::status_t       status_o,
  output ias_pkg::cnt_t          count_o,
  output logic                   is_empty_o,
  output logic [ias_pkg::CNT_W-1:0] upper_bound_o
);

  ias_pkg::word_t   entries_q [ias_pkg::DEPTH];
  ias_pkg::word_t   entries_d [ias_pkg::DEPTH];
  ias_pkg::word_t   up_src    [ias_pkg::DEPTH];
  ias_pkg::word_t   dn_src    [ias_pkg::DEPTH];
  ias_pkg::cnt_t    cnt_q, cnt_d;
  ias_pkg::cnt_t    cap_q;
  ias_pkg::cnt_t    cap_live;
  ias_pkg::op_t     op_q;
  ias_pkg::cnt_t    pos_q;
  ias_pkg::word_t   val_q;
  ias_pkg::word_t   rd_q, rd_d;
  ias_pkg::status_t st_q, st_d;
  logic             pos_in_list;
  logic             is_full;
  logic             ins_ok;
  logic             rem_ok;

  // capacity in force and range checks
  assign cap_live    = (cap_q < ias_pkg::CNT_W'(ias_pkg::DEPTH)) ? cap_q
                                                                 : ias_pkg::CNT_W'(ias_pkg::DEPTH);
  assign pos_in_list = (pos_q < cnt_q);
  assign is_full     = (cnt_q >= cap_live);
  assign ins_ok      = (op_q == ias_pkg::OP_INSERT) && (pos_q <= cnt_q) && !is_full;
  assign rem_ok      = (op_q == ias_pkg::OP_REMOVE) && pos_in_list;

  // neighbor words for the shift paths
  always_comb begin
    up_src[0]                   = val_q;
    dn_src[ias_pkg::DEPTH-1]    = entries_q[ias_pkg::DEPTH-1];
    for (int i = 1; i < ias_pkg::DEPTH; i++) begin
      up_src[i]   = entries_q[i-1];
      dn_src[i-1] = entries_q[i];
    end
  end

  // status, read word and new count
  always_comb begin
    st_d  = ias_pkg::ST_OK;
    rd_d  = '0;
    cnt_d = cnt_q;
    unique case (op_q)
      ias_pkg::OP_APPEND: begin
        if (is_full) st_d = ias_pkg::ST_FULL;
        else cnt_d = cnt_q + ias_pkg::CNT_W'(1);
      end
      ias_pkg::OP_WRITE: begin
        if (!pos_in_list) st_d = ias_pkg::ST_BADIDX;
      end
      ias_pkg::OP_READ: begin
        if (pos_in_list) rd_d = entries_q[pos_q[ias_pkg::IDX_W-1:0]];
        else st_d = ias_pkg::ST_BADIDX;
      end
      ias_pkg::OP_INSERT: begin
        if (pos_q > cnt_q) st_d = ias_pkg::ST_BADIDX;
        else if (is_full) st_d = ias_pkg::ST_FULL;
        else cnt_d = cnt_q + ias_pkg::CNT_W'(1);
      end
      ias_pkg::OP_REMOVE: begin
        if (pos_in_list) cnt_d = cnt_q - ias_pkg::CNT_W'(1);
        else st_d = ias_pkg::ST_BADIDX;
      end
      ias_pkg::OP_CLEAR: begin
        cnt_d = '0;
      end
      ias_pkg::OP_SETCOUNT: begin
        if (pos_q > cap_live) st_d = ias_pkg::ST_FULL;
        else cnt_d = pos_q;
      end
      default: begin
        st_d = ias_pkg::ST_BADIDX;
      end
    endcase
  end

  // per-entry next value; each entry looks only at itself and its neighbors
  always_comb begin
    for (int i = 0; i < ias_pkg::DEPTH; i++) begin
      entries_d[i] = entries_q[i];
      if (op_q == ias_pkg::OP_CLEAR) begin
        entries_d[i] = '0;
      end else if (op_q == ias_pkg::OP_APPEND && !is_full &&
                   cnt_q == ias_pkg::CNT_W'(i)) begin
        entries_d[i] = val_q;
      end else if (op_q == ias_pkg::OP_WRITE && pos_in_list &&
                   pos_q == ias_pkg::CNT_W'(i)) begin
        entries_d[i] = val_q;
      end else if (ins_ok) begin
        if (pos_q == ias_pkg::CNT_W'(i)) begin
          entries_d[i] = val_q;
        end else if (pos_q < ias_pkg::CNT_W'(i) && ias_pkg::CNT_W'(i) <= cnt_q) begin
          entries_d[i] = up_src[i];
        end
      end else if (rem_ok) begin
        if (pos_q <= ias_pkg::CNT_W'(i) &&
            (ias_pkg::CNT_W'(i) + ias_pkg::CNT_W'(1)) < cnt_q) begin
          entries_d[i] = dn_src[i];
        end
      end
    end
  end

  // list state and capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      cap_q <= ias_pkg::CNT_W'(16);
      for (int i = 0; i < ias_pkg::DEPTH; i++) begin
        entries_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.exec) begin
        cnt_q <= cnt_d;
        for (int i = 0; i < ias_pkg::DEPTH; i++) begin
          entries_q[i] <= entries_d[i];
        end
      end
    end
  end

  // item capture and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      pos_q <= pos_i;
      val_q <= val_i;
    end
    if (cmd_i.exec) begin
      rd_q <= rd_d;
      st_q <= st_d;
    end
  end

  // count, empty flag and upper bound follow the stored count
  assign read_value_o  = rd_q;
  assign status_o      = st_q;
  assign count_o       = cnt_q;
  assign is_empty_o    = (cnt_q == '0);
  assign upper_bound_o = cnt_q - ias_pkg::CNT_W'(1);

endmodule

@@ rtl/insertable_array_store_unit.sv @@
// top level of the insertable array store unit
// depends on ias_pkg, ias_ctrl and ias_dp
//
// An ordered store of up to 16 signed 32-bit words with insert and remove.
// Slave stream: each transfer carries one operation in s_axis_tuser and the
// position and word in s_axis_tdata. Master stream: one result per item with
// the read word, status, count, empty flag and upper bound.
// Config channel: cfg_data sets the capacity limit; always ready. The user
// must see that it is written only while the unit is idle; the block itself
// does not enforce this. An item goes through two steps: it is captured on
// the input transfer, then executed on the entry registers, where all entries
// shift together in one step, and the result is loaded into the output
// register. A new item is taken only after the previous one has executed.
// Stall: a result waits in the output register; the next item is still taken
// and held, and executes as soon as the waiting result transfers.
// Reset: all entries and the count clear to zero, capacity limit returns to 16.
module insertable_array_store_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // operation
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata, low bit up: position[4:0], value[36:5], zero fill
  input  logic [ias_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: operation[2:0]
  input  logic [ias_pkg::OP_W-1:0]        s_axis_tuser,
  // result
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata, low bit up: read_value[31:0], status[33:32], count[38:34],
  // is_empty[39], upper_bound[44:40], zero fill
  output logic [ias_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // capacity limit write
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ias_pkg::CNT_W-1:0]       cfg_data_i
);

  ias_pkg::cmd_t    cmd;
  ias_pkg::word_t   read_value;
  ias_pkg::status_t status;
  ias_pkg::cnt_t    count;
  logic             is_empty;
  logic [ias_pkg::CNT_W-1:0] upper_bound;

  assign cfg_ready_o = 1'b1;

  // sequencing
  ias_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // store and result
  ias_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .op_i          (s_axis_tuser),
    .pos_i         (s_axis_tdata[4:0]),
    .val_i         (s_axis_tdata[36:5]),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .read_value_o  (read_value),
    .status_o      (status),
    .count_o       (count),
    .is_empty_o    (is_empty),
    .upper_bound_o (upper_bound)
  );

  // result packing
  assign m_axis_tdata = {3'b000, upper_bound, is_empty, count, status, read_value};

endmodule

@@ test/tb_top.sv @@
// testbench for the insertable array store unit: random and directed operation streams
// checked against an in-bench shadow of the store; depends on ias_pkg and the rtl
`timescale 1ns / 100ps

module tb_top;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_ITEMS    = 64;
  localparam int NUM_PHASES     = 7;
  localparam int HOLD_PHASE     = 4;
  localparam int HOLD_CYCLES    = 80;
  localparam int TIMEOUT_CYCLES = 200000;

  // opcode the block does not define
  localparam ias_pkg::op_t OP_UNUSED = 3'd7;

  // capacity limit per random phase, phase 0 in the low bits
  localparam logic [NUM_PHASES-1:0][ias_pkg::CNT_W-1:0] PHASE_CAP =
    {5'd12, 5'd16, 5'd1, 5'd9, 5'd16, 5'd0, 5'd5};

  typedef struct packed {
    ias_pkg::op_t   op;
    ias_pkg::cnt_t  pos;
    ias_pkg::word_t value;
  } store_op_t;

  typedef struct packed {
    ias_pkg::word_t   read_value;
    ias_pkg::status_t status;
    ias_pkg::cnt_t    count;
    logic             is_empty;
    logic [4:0]       upper_bound;
  } store_result_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [ias_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [ias_pkg::OP_W-1:0]        s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [ias_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [ias_pkg::CNT_W-1:0]       cfg_data_i = '0;

  // stimulus and expectation queues
  store_op_t     pending_ops[$];
  store_result_t expected_results[$];
  store_op_t     offered_op;
  logic          op_taken = 1'b0;

  // shadow copy of the store
  ias_pkg::word_t shadow_words[ias_pkg::DEPTH] = '{default: '0};
  int             shadow_count = 0;
  ias_pkg::cnt_t  capacity_limit_q = 5'd16;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_left = 0;
  logic        hold_request = 1'b0;
  logic        hold_started = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned result_index = 0;

  insertable_array_store_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  // one operation on the shadow store, returns the result it should produce
  function automatic store_result_t apply_store_op(input store_op_t item);
    int cap;
    int n;
    int p;
    store_result_t res;
    cap = (capacity_limit_q < ias_pkg::DEPTH) ? int'(capacity_limit_q) : ias_pkg::DEPTH;
    n = shadow_count;
    p = int'(item.pos);
    res = '0;
    res.status = ias_pkg::ST_OK;
    case (item.op)
      ias_pkg::OP_APPEND: begin
        if (n >= cap) begin
          res.status = ias_pkg::ST_FULL;
        end else begin
          shadow_words[n] = item.value;
          n = n + 1;
        end
      end
      ias_pkg::OP_WRITE: begin
        if (p < n) shadow_words[p] = item.value;
        else res.status = ias_pkg::ST_BADIDX;
      end
      ias_pkg::OP_READ: begin
        if (p < n) res.read_value = shadow_words[p];
        else res.status = ias_pkg::ST_BADIDX;
      end
      ias_pkg::OP_INSERT: begin
        if (p > n) begin
          res.status = ias_pkg::ST_BADIDX;
        end else if (n >= cap) begin
          res.status = ias_pkg::ST_FULL;
        end else begin
          // later entries move up one slot
          for (int i = n; i > p; i--) shadow_words[i] = shadow_words[i - 1];
          shadow_words[p] = item.value;
          n = n + 1;
        end
      end
      ias_pkg::OP_REMOVE: begin
        if (p < n) begin
          // later entries move down, the old top word stays behind
          for (int i = p; i + 1 < n; i++) shadow_words[i] = shadow_words[i + 1];
          n = n - 1;
        end else begin
          res.status = ias_pkg::ST_BADIDX;
        end
      end
      ias_pkg::OP_CLEAR: begin
        foreach (shadow_words[i]) shadow_words[i] = '0;
        n = 0;
      end
      ias_pkg::OP_SETCOUNT: begin
        if (p > cap) res.status = ias_pkg::ST_FULL;
        else n = p;
      end
      default: begin
        res.status = ias_pkg::ST_BADIDX;
      end
    endcase
    shadow_count = n;
    res.count = ias_pkg::cnt_t'(n);
    res.is_empty = (n == 0);
    res.upper_bound = 5'(n - 1);
    return res;
  endfunction

  // random operation, weighted so the store fills up regularly
  function automatic store_op_t random_store_op();
    store_op_t item;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 22) item.op = ias_pkg::OP_APPEND;
    else if (pick < 36) item.op = ias_pkg::OP_INSERT;
    else if (pick < 52) item.op = ias_pkg::OP_WRITE;
    else if (pick < 70) item.op = ias_pkg::OP_READ;
    else if (pick < 84) item.op = ias_pkg::OP_REMOVE;
    else if (pick < 93) item.op = ias_pkg::OP_SETCOUNT;
    else if (pick < 97) item.op = ias_pkg::OP_CLEAR;
    else item.op = OP_UNUSED;
    item.pos = ias_pkg::cnt_t'($urandom_range(16));
    case ($urandom_range(15))
      0: item.value = 32'h8000_0000;
      1: item.value = 32'h7fff_ffff;
      2: item.value = '1;
      3: item.value = '0;
      default: item.value = $urandom;
    endcase
    return item;
  endfunction

  task automatic queue_op(input ias_pkg::op_t op, input int pos, input ias_pkg::word_t value);
    store_op_t item;
    item.op = op;
    item.pos = ias_pkg::cnt_t'(pos);
    item.value = value;
    pending_ops.push_back(item);
  endtask

  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    $display("mismatch at result %0d: %s got %h want %h", result_index, field, got, want);
  endtask

  // capacity limit write, only called while the block is idle
  task automatic write_capacity(input ias_pkg::cnt_t limit);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= limit;
    do @(posedge clk_i); while (!cfg_ready_o);
    capacity_limit_q = limit;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // wait until every item is taken and every result has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_ops.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // operation source
  always @(negedge clk_i) begin : drive_store_ops
    if (rst_ni && (!s_axis_tvalid || op_taken)) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        offered_op = pending_ops.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, offered_op.value, offered_op.pos};
        s_axis_tuser <= offered_op.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink ready, with random gaps and the long hold-off
  always @(negedge clk_i) begin : drive_result_ready
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // hold-off countdown, started once on request
  always @(posedge clk_i) begin : count_hold
    if (hold_request && !hold_started) begin
      hold_left <= HOLD_CYCLES;
      hold_started <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // check result transfers, then predict for the accepted operation
  always @(posedge clk_i) begin : track_transfers
    store_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("unexpected result", m_axis_tdata[31:0], '0);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata[31:0] !== want.read_value)
            flag_mismatch("read_value", m_axis_tdata[31:0], want.read_value);
          if (m_axis_tdata[33:32] !== want.status)
            flag_mismatch("status", 32'(m_axis_tdata[33:32]), 32'(want.status));
          if (m_axis_tdata[38:34] !== want.count)
            flag_mismatch("count", 32'(m_axis_tdata[38:34]), 32'(want.count));
          if (m_axis_tdata[39] !== want.is_empty)
            flag_mismatch("is_empty", 32'(m_axis_tdata[39]), 32'(want.is_empty));
          if (m_axis_tdata[44:40] !== want.upper_bound)
            flag_mismatch("upper_bound", 32'(m_axis_tdata[44:40]), 32'(want.upper_bound));
        end
        result_index++;
      end
      op_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(apply_store_op(offered_op));
    end
  end

  initial begin : run_sequence
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    tx_idle_pct = 6;
    rx_idle_pct = 54;
    write_capacity(5'd16);

    // empty store: every indexed access is out of range
    queue_op(ias_pkg::OP_READ, 0, 32'h1234_5678);
    queue_op(ias_pkg::OP_REMOVE, 0, '0);
    queue_op(ias_pkg::OP_INSERT, 1, 32'h0000_0001);
    queue_op(ias_pkg::OP_WRITE, 0, 32'hdead_beef);
    // build up with field extremes
    queue_op(ias_pkg::OP_INSERT, 0, 32'h7fff_ffff);
    queue_op(ias_pkg::OP_APPEND, 3, 32'h8000_0000);
    queue_op(ias_pkg::OP_APPEND, 16, '1);
    queue_op(ias_pkg::OP_INSERT, 1, 32'h5555_5555);
    queue_op(ias_pkg::OP_INSERT, 4, 32'haaaa_aaaa);
    queue_op(ias_pkg::OP_WRITE, 2, '0);
    queue_op(ias_pkg::OP_READ, 0, '0);
    queue_op(ias_pkg::OP_READ, 4, '0);
    queue_op(ias_pkg::OP_READ, 5, '0);
    // remove leaves the top word behind, set count exposes it again
    queue_op(ias_pkg::OP_REMOVE, 4, '0);
    queue_op(ias_pkg::OP_REMOVE, 0, '0);
    queue_op(ias_pkg::OP_SETCOUNT, 5, '0);
    queue_op(ias_pkg::OP_READ, 4, '0);
    // capacity edges
    queue_op(ias_pkg::OP_SETCOUNT, 16, '0);
    queue_op(ias_pkg::OP_APPEND, 0, 32'h0f0f_0f0f);
    queue_op(ias_pkg::OP_INSERT, 16, 32'hf0f0_f0f0);
    queue_op(ias_pkg::OP_READ, 15, '0);
    queue_op(ias_pkg::OP_REMOVE, 16, '0);
    queue_op(OP_UNUSED, 7, 32'hffff_ffff);
    queue_op(ias_pkg::OP_CLEAR, 0, '0);
    queue_op(ias_pkg::OP_READ, 0, '0);
    // leave entries in place so the next limit sits below the count
    queue_op(ias_pkg::OP_SETCOUNT, 10, '0);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_capacity(PHASE_CAP[ph]);
      tx_idle_pct = (ph < 2) ? 6 : (ph < 4) ? 54 : 0;
      rx_idle_pct = (ph < 2) ? 54 : (ph < 4) ? 6 : 0;
      for (int k = 0; k < PHASE_ITEMS; k++) pending_ops.push_back(random_store_op());
      // receiver stalls for a while so the input side backs up
      if (ph == HOLD_PHASE) hold_request = 1'b1;
      wait_drained();
    end

    if (expected_results.size() != 0)
      flag_mismatch("missing results", expected_results.size(), '0);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
